[rtl/dps_pkg.sv]
package dps_pkg;

    localparam int CountWidth = 10;

    // Request codes carried in the func field
    typedef enum logic [1:0] {
        FN_POLL  = 2'd0,
        FN_START = 2'd1,
        FN_STOP  = 2'd2,
        FN_QSTOP = 2'd3
    } t_func;

    // Decoded drive power state
    typedef enum logic [3:0] {
        DS_NOT_READY      = 4'd0,
        DS_SWITCH_DISABLE = 4'd1,
        DS_READY          = 4'd2,
        DS_SWITCHED_ON    = 4'd3,
        DS_ENABLED        = 4'd4,
        DS_QUICK_STOP     = 4'd5,
        DS_FAULT_REACTION = 4'd6,
        DS_FAULT          = 4'd7,
        DS_UNKNOWN        = 4'd8
    } t_drive_state;

    // Running sequence, one-hot
    typedef enum logic [3:0] {
        SQ_IDLE  = 4'b0001,
        SQ_START = 4'b0010,
        SQ_STOP  = 4'b0100,
        SQ_QSTOP = 4'b1000
    } t_seq;

    localparam logic [15:0] CwReset      = 16'h0004;
    localparam logic [15:0] CwQuickStop  = 16'h0004;
    localparam logic [15:0] CwShutdown   = 16'h0006;
    localparam logic [15:0] CwSwitchOn   = 16'h0007;
    localparam logic [15:0] CwEnable     = 16'h000F;
    localparam logic [15:0] CwFaultReset = 16'h0080;
    localparam logic [15:0] CwQsKeepMask = 16'h7F7B;
    localparam logic [15:0] CwQsSetMask  = 16'h0002;
    localparam logic [CountWidth-1:0] PollLimitReset = 10'd100;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] drv_status;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cmd_word;
        logic [3:0]  drive_state;
        logic        in_fault;
        logic [7:0]  error_byte;
        logic        busy_res;
        logic        done_ok;
        logic        done_fail;
    } t_out_item;

    // Sequencer state carried from poll to poll
    typedef struct packed {
        logic [15:0]           drive_control;
        t_seq                  seq;
        logic [CountWidth-1:0] poll_count;
    } t_ctl;

    // Standard status word decode over bits 0-3, 5 and 6
    function automatic t_drive_state decode_state(input logic [15:0] sw);
        logic [7:0] m4f;
        logic [7:0] m6f;
        t_drive_state st;
        m4f = sw[7:0] & 8'h4F;
        m6f = sw[7:0] & 8'h6F;
        priority if (m4f == 8'h00) st = DS_NOT_READY;
        else if (m4f == 8'h40)     st = DS_SWITCH_DISABLE;
        else if (m6f == 8'h21)     st = DS_READY;
        else if (m6f == 8'h23)     st = DS_SWITCHED_ON;
        else if (m6f == 8'h27)     st = DS_ENABLED;
        else if (m6f == 8'h07)     st = DS_QUICK_STOP;
        else if (m4f == 8'h0F)     st = DS_FAULT_REACTION;
        else if (m4f == 8'h08)     st = DS_FAULT;
        else                       st = DS_UNKNOWN;
        return st;
    endfunction

endpackage

[rtl/dps_step.sv]
module dps_step
    import dps_pkg::*;
(
    input  t_ctl                  i_ctl,
    input  t_in_item              i_item,
    input  logic [CountWidth-1:0] i_poll_limit,
    output t_ctl                  o_ctl,
    output t_out_item             o_item
);

    t_drive_state st;
    t_func        fn;
    t_seq         seq_req;
    t_ctl         ctl_req;
    t_ctl         ctl_nxt;
    t_drive_state goal;
    logic         ok;
    logic         fail;

    assign st = decode_state(i_item.drv_status);
    assign fn = t_func'(i_item.func);

    // Apply a new request: it replaces any running sequence
    always_comb begin
        unique case (fn)
            FN_START: seq_req = SQ_START;
            FN_STOP:  seq_req = SQ_STOP;
            FN_QSTOP: seq_req = SQ_QSTOP;
            default:  seq_req = SQ_IDLE;
        endcase
        ctl_req = i_ctl;
        if (fn != FN_POLL) begin
            ctl_req.seq        = seq_req;
            ctl_req.poll_count = '0;
        end
        if (fn == FN_QSTOP) begin
            ctl_req.drive_control = (i_ctl.drive_control & CwQsKeepMask) | CwQsSetMask;
        end
    end

    // Goal state of the running sequence
    always_comb begin
        unique case (ctl_req.seq)
            SQ_START: goal = DS_ENABLED;
            SQ_STOP:  goal = DS_SWITCH_DISABLE;
            default:  goal = DS_QUICK_STOP;
        endcase
    end

    // Check goal, then poll budget, else step the start/stop control word
    always_comb begin
        ctl_nxt = ctl_req;
        ok      = 1'b0;
        fail    = 1'b0;
        if (ctl_req.seq != SQ_IDLE) begin
            priority if (st == goal) begin
                ok                 = 1'b1;
                ctl_nxt.seq        = SQ_IDLE;
                ctl_nxt.poll_count = '0;
            end else if (ctl_req.poll_count >= i_poll_limit) begin
                fail               = 1'b1;
                ctl_nxt.seq        = SQ_IDLE;
                ctl_nxt.poll_count = '0;
            end else begin
                ctl_nxt.poll_count = ctl_req.poll_count + 1'b1;
                if (ctl_req.seq == SQ_START) begin
                    unique case (st)
                        DS_FAULT:          ctl_nxt.drive_control = CwFaultReset;
                        DS_QUICK_STOP:     ctl_nxt.drive_control = CwQuickStop;
                        DS_SWITCH_DISABLE: ctl_nxt.drive_control = CwShutdown;
                        DS_READY:          ctl_nxt.drive_control = CwSwitchOn;
                        DS_SWITCHED_ON:    ctl_nxt.drive_control = CwEnable;
                        default:           ctl_nxt.drive_control = ctl_req.drive_control;
                    endcase
                end else if (ctl_req.seq == SQ_STOP) begin
                    unique case (st)
                        DS_ENABLED:        ctl_nxt.drive_control = CwSwitchOn;
                        DS_SWITCHED_ON:    ctl_nxt.drive_control = CwShutdown;
                        DS_READY:          ctl_nxt.drive_control = CwQuickStop;
                        DS_FAULT:          ctl_nxt.drive_control = CwFaultReset;
                        DS_QUICK_STOP:     ctl_nxt.drive_control = CwQuickStop;
                        default:           ctl_nxt.drive_control = ctl_req.drive_control;
                    endcase
                end
            end
        end
    end

    assign o_ctl = ctl_nxt;

    // Build the result item
    always_comb begin
        o_item.cmd_word    = ctl_nxt.drive_control;
        o_item.drive_state = st;
        o_item.in_fault    = (st == DS_FAULT) || (st == DS_FAULT_REACTION);
        o_item.error_byte  = i_item.drv_status[15:8];
        o_item.busy_res    = (ctl_nxt.seq != SQ_IDLE);
        o_item.done_ok     = ok;
        o_item.done_fail   = fail;
    end

endmodule

[rtl/drive_power_state_sequencer_core.sv]
// Drive power state sequencer, master side. Each input item is one poll
// carrying the drive's status word and an optional request (start up, shut
// down, quick stop); each poll yields exactly one result item with the
// control word to send, the decoded drive state, fault flag, the status
// word's upper byte, a busy flag and done pulses. A poll passes through an
// input register and a result register, and one poll is accepted every
// cycle while the result side keeps up. The sequencer state is updated as
// a poll moves from the input register to the result register. poll_limit
// (reset 100) is written through i_cfg_we / i_cfg_data; the user must write
// it only while no poll is in flight, as the block does not enforce this.
module drive_power_state_sequencer_core
    import dps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CountWidth-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    logic [CountWidth-1:0] r_poll_limit;
    logic                  r_in_valid;
    t_in_item              r_in_item;
    logic                  r_out_valid;
    t_out_item             r_out_item;
    t_ctl                  r_ctl;
    t_ctl                  n_ctl;
    t_out_item             n_out_item;
    logic                  advance;

    // Move the held item forward when the result register is empty or being read
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    dps_step u_step (
        .i_ctl        (r_ctl),
        .i_item       (r_in_item),
        .i_poll_limit (r_poll_limit),
        .o_ctl        (n_ctl),
        .o_item       (n_out_item)
    );

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= PollLimitReset;
        end else if (i_cfg_we) begin
            r_poll_limit <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // Sequencer state, updated once per poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.drive_control <= CwReset;
            r_ctl.seq           <= SQ_IDLE;
            r_ctl.poll_count    <= '0;
        end else if (advance) begin
            r_ctl <= n_ctl;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[rtl/dps_checker.sv]
module dps_checker
    import dps_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // Both done pulses never show in one result
    a_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.done_ok && o_out_item.done_fail))
        else $error("done_ok and done_fail both set");

    // A finished sequence is no longer busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.done_ok || o_out_item.done_fail))
            |-> !o_out_item.busy_res)
        else $error("busy after sequence end");

    // Fault flag follows the decoded state
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.in_fault ==
            ((o_out_item.drive_state == DS_FAULT) ||
             (o_out_item.drive_state == DS_FAULT_REACTION))))
        else $error("in_fault does not match drive_state");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result item changed");

endmodule

bind drive_power_state_sequencer_core dps_checker u_dps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
